FILE: design/bppc_pkg.sv
// ----------------------------------------------------------------------------
// bppc_pkg
// Types and constants shared by the box pair penetration contact block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bppc_pkg;

    localparam int unsigned COORD_W = 32;
    localparam int unsigned SLOP_W  = 16;
    localparam int unsigned PEN_W   = 31;
    // Overlap spans -(2^32 - 1) .. 2^32 and needs 34 signed bits.
    localparam int unsigned OVL_W   = 34;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    localparam logic [SLOP_W-1:0] SLOP_RESET = 16'd7;

    typedef struct packed {
        logic signed [COORD_W-1:0] left_center_x;
        logic signed [COORD_W-1:0] left_center_y;
        logic signed [COORD_W-1:0] left_center_z;
        logic signed [COORD_W-1:0] left_half_x;
        logic signed [COORD_W-1:0] left_half_y;
        logic signed [COORD_W-1:0] left_half_z;
        logic signed [COORD_W-1:0] right_center_x;
        logic signed [COORD_W-1:0] right_center_y;
        logic signed [COORD_W-1:0] right_center_z;
        logic signed [COORD_W-1:0] right_half_x;
        logic signed [COORD_W-1:0] right_half_y;
        logic signed [COORD_W-1:0] right_half_z;
    } t_box_pair;

    typedef struct packed {
        logic                      touching;
        logic [1:0]                normal_axis;
        logic                      normal_negative;
        logic [PEN_W-1:0]          penetration;
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
    } t_contact;

    // Per-axis intermediate results held between the two pipeline stages.
    typedef struct packed {
        logic signed [OVL_W-1:0]   overlap;
        logic                      delta_negative;
        logic signed [COORD_W-1:0] midpoint;
    } t_axis_info;

endpackage

`default_nettype wire

FILE: design/bppc_axis.sv
// ----------------------------------------------------------------------------
// bppc_axis
// Overlap, delta sign and centre midpoint along one axis.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bppc_axis (
    input  wire logic signed [bppc_pkg::COORD_W-1:0] i_left_center,
    input  wire logic signed [bppc_pkg::COORD_W-1:0] i_left_half,
    input  wire logic signed [bppc_pkg::COORD_W-1:0] i_right_center,
    input  wire logic signed [bppc_pkg::COORD_W-1:0] i_right_half,
    output bppc_pkg::t_axis_info                    o_info
);

    localparam int unsigned CW = bppc_pkg::COORD_W;

    logic signed [CW:0] left_ext;
    logic signed [CW:0] right_ext;
    logic signed [CW:0] delta;
    logic signed [CW:0] center_sum;
    logic [CW-1:0]      left_abs;
    logic [CW-1:0]      right_abs;
    logic [CW-1:0]      delta_abs;

    assign left_ext  = {i_left_half[CW-1], i_left_half};
    assign right_ext = {i_right_half[CW-1], i_right_half};

    // The most negative extent gives 2^31, which still fits unsigned in 32 bits.
    assign left_abs  = left_ext[CW]  ? CW'(-left_ext)  : CW'(left_ext);
    assign right_abs = right_ext[CW] ? CW'(-right_ext) : CW'(right_ext);

    assign delta      = {i_right_center[CW-1], i_right_center}
                      - {i_left_center[CW-1], i_left_center};
    assign delta_abs  = delta[CW] ? CW'(-delta) : CW'(delta);
    assign center_sum = {i_right_center[CW-1], i_right_center}
                      + {i_left_center[CW-1], i_left_center};

    always_comb begin
        o_info.overlap        = $signed({2'b00, left_abs}) + $signed({2'b00, right_abs})
                              - $signed({2'b00, delta_abs});
        o_info.delta_negative = delta[CW];
        // Arithmetic shift of the sum rounds toward minus infinity.
        o_info.midpoint       = center_sum[CW:1];
    end

endmodule

`default_nettype wire

FILE: design/bppc_select.sv
// ----------------------------------------------------------------------------
// bppc_select
// Separation test, least-overlap axis choice and result formatting.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bppc_select (
    input  wire bppc_pkg::t_axis_info             i_axis_x,
    input  wire bppc_pkg::t_axis_info             i_axis_y,
    input  wire bppc_pkg::t_axis_info             i_axis_z,
    input  wire logic [bppc_pkg::SLOP_W-1:0]      i_slop,
    output bppc_pkg::t_contact                    o_contact
);

    localparam int unsigned OW = bppc_pkg::OVL_W;
    localparam int unsigned PW = bppc_pkg::PEN_W;
    localparam int unsigned SW = bppc_pkg::SLOP_W;

    logic signed [OW-1:0] neg_slop;
    logic                 apart;
    logic [1:0]           axis;
    bppc_pkg::t_axis_info chosen;
    logic [PW-1:0]        pen;

    assign neg_slop = -$signed({{(OW-SW){1'b0}}, i_slop});
    assign apart    = (i_axis_x.overlap < neg_slop) || (i_axis_y.overlap < neg_slop)
                   || (i_axis_z.overlap < neg_slop);

    always_comb begin
        priority if (i_axis_y.overlap < i_axis_x.overlap
                     && i_axis_y.overlap <= i_axis_z.overlap) begin
            axis = bppc_pkg::AXIS_Y;
        end else if (i_axis_z.overlap < i_axis_x.overlap
                     && i_axis_z.overlap < i_axis_y.overlap) begin
            axis = bppc_pkg::AXIS_Z;
        end else begin
            axis = bppc_pkg::AXIS_X;
        end
    end

    always_comb begin
        unique case (axis)
            bppc_pkg::AXIS_Y: chosen = i_axis_y;
            bppc_pkg::AXIS_Z: chosen = i_axis_z;
            default:          chosen = i_axis_x;
        endcase
    end

    // Clamp at zero and saturate to the largest 31-bit value.
    always_comb begin
        priority if (chosen.overlap[OW-1]) begin
            pen = '0;
        end else if (|chosen.overlap[OW-2:PW]) begin
            pen = '1;
        end else begin
            pen = chosen.overlap[PW-1:0];
        end
    end

    always_comb begin
        o_contact = '0;
        if (!apart) begin
            o_contact.touching        = 1'b1;
            o_contact.normal_axis     = axis;
            o_contact.normal_negative = chosen.delta_negative;
            o_contact.penetration     = pen;
            o_contact.point_x         = i_axis_x.midpoint;
            o_contact.point_y         = i_axis_y.midpoint;
            o_contact.point_z         = i_axis_z.midpoint;
        end
    end

endmodule

`default_nettype wire

FILE: design/box_pair_penetration_contact.sv
// ----------------------------------------------------------------------------
// box_pair_penetration_contact
// Contact test for two axis-aligned boxes: least-overlap axis, depth, point.
// ----------------------------------------------------------------------------
//  Channel  Signals                               Direction
//  input    i_in_valid, o_in_ready, i_in_data     box pair in
//  output   o_out_valid, i_out_ready, o_out_data  contact out
//  config   i_cfg_we, i_cfg_data                  contact_slop write
//
// One box pair is taken every cycle unless the pipeline is full behind a stalled output;
// its result passes through the input register, the per-axis overlap register and the result register.
// The per-axis adders and the three-way overlap compare set the cycle time.
// Reset is synchronous, active low, empties the pipeline and sets the slop to 7.
// A stalled output holds its result; each stage still fills while a later one
// waits, so up to three items sit in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module box_pair_penetration_contact (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire bppc_pkg::t_box_pair              i_in_data,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output bppc_pkg::t_contact                    o_out_data,
    input  wire logic                             i_cfg_we,
    input  wire logic [bppc_pkg::SLOP_W-1:0]      i_cfg_data
);

    logic                            r_in_valid;
    bppc_pkg::t_box_pair             r_in;
    logic                            r_mid_valid;
    bppc_pkg::t_axis_info            r_axis_x;
    bppc_pkg::t_axis_info            r_axis_y;
    bppc_pkg::t_axis_info            r_axis_z;
    logic                            r_out_valid;
    bppc_pkg::t_contact              r_out;
    logic [bppc_pkg::SLOP_W-1:0]     r_contact_slop;

    bppc_pkg::t_axis_info            n_axis_x;
    bppc_pkg::t_axis_info            n_axis_y;
    bppc_pkg::t_axis_info            n_axis_z;
    bppc_pkg::t_contact              n_out;

    logic out_adv;
    logic mid_adv;
    logic in_adv;

    assign out_adv    = !r_out_valid || i_out_ready;
    assign mid_adv    = !r_mid_valid || out_adv;
    assign in_adv     = !r_in_valid || mid_adv;
    assign o_in_ready = in_adv;

    bppc_axis u_axis_x (
        .i_left_center  (r_in.left_center_x),
        .i_left_half    (r_in.left_half_x),
        .i_right_center (r_in.right_center_x),
        .i_right_half   (r_in.right_half_x),
        .o_info         (n_axis_x)
    );

    bppc_axis u_axis_y (
        .i_left_center  (r_in.left_center_y),
        .i_left_half    (r_in.left_half_y),
        .i_right_center (r_in.right_center_y),
        .i_right_half   (r_in.right_half_y),
        .o_info         (n_axis_y)
    );

    bppc_axis u_axis_z (
        .i_left_center  (r_in.left_center_z),
        .i_left_half    (r_in.left_half_z),
        .i_right_center (r_in.right_center_z),
        .i_right_half   (r_in.right_half_z),
        .o_info         (n_axis_z)
    );

    bppc_select u_select (
        .i_axis_x  (r_axis_x),
        .i_axis_y  (r_axis_y),
        .i_axis_z  (r_axis_z),
        .i_slop    (r_contact_slop),
        .o_contact (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_mid_valid    <= 1'b0;
            r_out_valid    <= 1'b0;
            r_contact_slop <= bppc_pkg::SLOP_RESET;
        end else begin
            if (in_adv) begin
                r_in_valid <= i_in_valid;
            end
            if (mid_adv) begin
                r_mid_valid <= r_in_valid;
            end
            if (out_adv) begin
                r_out_valid <= r_mid_valid;
            end
            if (i_cfg_we) begin
                r_contact_slop <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_adv && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (mid_adv && r_in_valid) begin
            r_axis_x <= n_axis_x;
            r_axis_y <= n_axis_y;
            r_axis_z <= n_axis_z;
        end
        if (out_adv && r_mid_valid) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

FILE: design/bppc_checker.sv
// ----------------------------------------------------------------------------
// bppc_checker
// Port-level checks for the box pair penetration contact block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bppc_checker (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             o_in_ready,
    input  wire logic                             o_out_valid,
    input  wire logic                             i_out_ready,
    input  wire bppc_pkg::t_contact               o_out_data
);

    // A stalled result transfer keeps its valid and its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output result changed while stalled");

    // The input side only stalls when every stage is full behind a stalled output.
    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("input stalled while the output is free");

    // Separated boxes report an all-zero result.
    a_apart_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.touching |->
            o_out_data.normal_axis == bppc_pkg::AXIS_X && !o_out_data.normal_negative
            && o_out_data.penetration == '0 && o_out_data.point_x == '0
            && o_out_data.point_y == '0 && o_out_data.point_z == '0)
        else $error("separated result carries nonzero fields");

    // A touching result names one of the three axes.
    a_axis_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.touching |->
            o_out_data.normal_axis == bppc_pkg::AXIS_X
            || o_out_data.normal_axis == bppc_pkg::AXIS_Y
            || o_out_data.normal_axis == bppc_pkg::AXIS_Z)
        else $error("touching result with an invalid axis");

    // Nothing comes out in the cycle after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

endmodule

bind box_pair_penetration_contact bppc_checker u_bppc_checker (.*);

`default_nettype wire

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the box pair penetration contact block.
// A queue-fed driver sends box pairs in bursts with random gaps while the
// result side stalls on its own pattern. Every accepted pair is predicted
// in 64-bit arithmetic, and each contact coming out is checked field by field
// against the oldest prediction. The run covers directed corner pairs and
// then random pairs under several contact_slop settings, the extremes
// included. The slop is only changed while nothing is in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    localparam int     PIPE_DEPTH  = 3;
    localparam int     QUIET_LIMIT = 2000;
    localparam int     ONE         = 65536;
    localparam int     CW          = bppc_pkg::COORD_W;
    localparam int     SW          = bppc_pkg::SLOP_W;
    localparam int     PW          = bppc_pkg::PEN_W;
    localparam longint COORD_MIN   = -(longint'(1) << 31);
    localparam longint COORD_MAX   = (longint'(1) << 31) - 1;
    localparam longint DELTA_MAX   = (longint'(1) << 32) - 1;
    localparam longint PEN_MAX     = (longint'(1) << PW) - 1;
    localparam longint NEAR        = longint'(1) << 20;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    bppc_pkg::t_box_pair in_data   = '0;
    logic                out_valid;
    logic                out_ready = 1'b1;
    bppc_pkg::t_contact  out_data;
    logic                cfg_we    = 1'b0;
    logic [SW-1:0]       cfg_data  = '0;

    bppc_pkg::t_box_pair pending_pairs[$];
    bppc_pkg::t_contact  expected_contacts[$];
    logic [SW-1:0]       cur_slop = bppc_pkg::SLOP_RESET;

    int burst_left   = 1;
    int gap_left     = 0;
    int ready_run    = 0;
    int quiet_cycles = 0;
    int errors       = 0;
    int pairs_sent   = 0;
    int checked      = 0;
    int slop_writes  = 0;
    int touch_count  = 0;
    int apart_count  = 0;
    int neg_count    = 0;
    int sat_count    = 0;
    int axis_hits[3] = '{0, 0, 0};

    box_pair_penetration_contact dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic bppc_pkg::t_contact predict_contact(bppc_pkg::t_box_pair p,
                                                           logic [SW-1:0] slop);
        longint             lc[3], lh[3], rc[3], rh[3], delta[3], ovl[3];
        longint             le, re, pen, mid;
        int                 i;
        logic [1:0]         axis;
        bppc_pkg::t_contact c;
        lc[0] = p.left_center_x;  lc[1] = p.left_center_y;  lc[2] = p.left_center_z;
        lh[0] = p.left_half_x;    lh[1] = p.left_half_y;    lh[2] = p.left_half_z;
        rc[0] = p.right_center_x; rc[1] = p.right_center_y; rc[2] = p.right_center_z;
        rh[0] = p.right_half_x;   rh[1] = p.right_half_y;   rh[2] = p.right_half_z;
        for (i = 0; i < 3; i++) begin
            le = (lh[i] < 0) ? -lh[i] : lh[i];
            re = (rh[i] < 0) ? -rh[i] : rh[i];
            delta[i] = rc[i] - lc[i];
            ovl[i] = le + re - ((delta[i] < 0) ? -delta[i] : delta[i]);
        end
        c = '0;
        for (i = 0; i < 3; i++) begin
            if (ovl[i] < -longint'(slop))
                return c;
        end
        if (ovl[1] < ovl[0] && ovl[1] <= ovl[2])
            axis = bppc_pkg::AXIS_Y;
        else if (ovl[2] < ovl[0] && ovl[2] < ovl[1])
            axis = bppc_pkg::AXIS_Z;
        else
            axis = bppc_pkg::AXIS_X;
        pen = ovl[axis];
        if (pen < 0)
            pen = 0;
        if (pen > PEN_MAX)
            pen = PEN_MAX;
        c.touching        = 1'b1;
        c.normal_axis     = axis;
        c.normal_negative = delta[axis] < 0;
        c.penetration     = pen[PW-1:0];
        // An arithmetic shift of the 64-bit sum rounds the midpoint toward minus infinity.
        mid = (lc[0] + rc[0]) >>> 1;
        c.point_x = mid[CW-1:0];
        mid = (lc[1] + rc[1]) >>> 1;
        c.point_y = mid[CW-1:0];
        mid = (lc[2] + rc[2]) >>> 1;
        c.point_z = mid[CW-1:0];
        return c;
    endfunction

    function automatic string contact_str(bppc_pkg::t_contact c);
        return $sformatf("touch=%0b axis=%0d neg=%0b pen=0x%08h point=(%0d, %0d, %0d)",
                         c.touching, c.normal_axis, c.normal_negative, c.penetration,
                         c.point_x, c.point_y, c.point_z);
    endfunction

    function automatic void add_pair(bppc_pkg::t_box_pair p);
        pending_pairs.insert(pending_pairs.size(), p);
    endfunction

    function automatic bppc_pkg::t_box_pair set_axis(bppc_pkg::t_box_pair p, int a,
                                                     longint lc, longint lh,
                                                     longint rc, longint rh);
        bppc_pkg::t_box_pair q;
        q = p;
        case (a)
            bppc_pkg::AXIS_X: begin
                q.left_center_x  = lc[CW-1:0];
                q.left_half_x    = lh[CW-1:0];
                q.right_center_x = rc[CW-1:0];
                q.right_half_x   = rh[CW-1:0];
            end
            bppc_pkg::AXIS_Y: begin
                q.left_center_y  = lc[CW-1:0];
                q.left_half_y    = lh[CW-1:0];
                q.right_center_y = rc[CW-1:0];
                q.right_half_y   = rh[CW-1:0];
            end
            bppc_pkg::AXIS_Z: begin
                q.left_center_z  = lc[CW-1:0];
                q.left_half_z    = lh[CW-1:0];
                q.right_center_z = rc[CW-1:0];
                q.right_half_z   = rh[CW-1:0];
            end
            default: ;
        endcase
        return q;
    endfunction

    function automatic bppc_pkg::t_box_pair uniform_pair(longint lc, longint lh,
                                                         longint rc, longint rh);
        bppc_pkg::t_box_pair p;
        p = '0;
        p = set_axis(p, bppc_pkg::AXIS_X, lc, lh, rc, rh);
        p = set_axis(p, bppc_pkg::AXIS_Y, lc, lh, rc, rh);
        p = set_axis(p, bppc_pkg::AXIS_Z, lc, lh, rc, rh);
        return p;
    endfunction

    function automatic longint rand_between(longint lo, longint hi);
        logic [63:0] span;
        logic [63:0] r;
        span = hi - lo + 1;
        r = {$urandom, $urandom};
        return lo + longint'(r % span);
    endfunction

    function automatic longint pick_extent();
        int bits;
        bits = ($urandom_range(0, 3) == 0) ? $urandom_range(24, 31) : $urandom_range(0, 22);
        return longint'($urandom) & ((longint'(1) << bits) - 1);
    endfunction

    function automatic longint signed_extent(longint m);
        return ($urandom_range(0, 3) == 0) ? -m : m;
    endfunction

    // Target overlap for one axis; several choices sit right on the slop boundary.
    function automatic longint pick_overlap(longint sum, logic [SW-1:0] slop);
        longint s;
        longint v;
        s = longint'(slop);
        case ($urandom_range(0, 15))
            0:       v = -s;
            1:       v = -s - 1;
            2:       v = 0;
            3:       v = sum;
            4:       v = -s - longint'($urandom_range(2, 5000));
            5:       v = -longint'($urandom_range(0, slop));
            default: v = rand_between(0, sum);
        endcase
        return v;
    endfunction

    function automatic bppc_pkg::t_box_pair touching_pair(logic [SW-1:0] slop);
        longint              le[3], re[3], ovl[3];
        longint              dmag, delta, lo, hi, lc;
        int                  i, src, dst;
        bppc_pkg::t_box_pair p;
        p = '0;
        for (i = 0; i < 3; i++) begin
            le[i] = pick_extent();
            re[i] = pick_extent();
            ovl[i] = pick_overlap(le[i] + re[i], slop);
        end
        // Copy whole axes over now and then so that the tie rules get exercised.
        if ($urandom_range(0, 7) == 0) begin
            for (i = 1; i < 3; i++) begin
                le[i] = le[0];
                re[i] = re[0];
                ovl[i] = ovl[0];
            end
        end else if ($urandom_range(0, 2) == 0) begin
            src = $urandom_range(0, 1);
            dst = $urandom_range(src + 1, 2);
            le[dst] = le[src];
            re[dst] = re[src];
            ovl[dst] = ovl[src];
        end
        for (i = 0; i < 3; i++) begin
            dmag = le[i] + re[i] - ovl[i];
            if (dmag < 0)
                dmag = 0;
            if (dmag > DELTA_MAX)
                dmag = DELTA_MAX;
            delta = ($urandom_range(0, 1) == 0) ? -dmag : dmag;
            lo = (delta > 0) ? COORD_MIN : COORD_MIN - delta;
            hi = (delta > 0) ? COORD_MAX - delta : COORD_MAX;
            if ($urandom_range(0, 1) == 0 && lo <= NEAR && hi >= -NEAR) begin
                if (lo < -NEAR)
                    lo = -NEAR;
                if (hi > NEAR)
                    hi = NEAR;
            end
            lc = rand_between(lo, hi);
            p = set_axis(p, i, lc, signed_extent(le[i]), lc + delta, signed_extent(re[i]));
        end
        return p;
    endfunction

    function automatic bppc_pkg::t_box_pair noise_pair();
        bppc_pkg::t_box_pair p;
        int                  i;
        for (i = 0; i < 12; i++)
            p[i * CW +: CW] = $urandom;
        return p;
    endfunction

    task automatic queue_random(int count);
        @(negedge clk);
        repeat (count) begin
            if ($urandom_range(0, 99) < 12)
                add_pair(noise_pair());
            else
                add_pair(touching_pair(cur_slop));
        end
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_pairs.size() != 0 || expected_contacts.size() != 0 || in_valid);
        repeat (PIPE_DEPTH + 2) @(posedge clk);
    endtask

    task automatic write_slop(logic [SW-1:0] value);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
        cur_slop = value;
        slop_writes++;
    endtask

    // Sender: bursts of random length separated by random gaps.
    always @(posedge clk) begin : drive_pairs
        logic show;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_ready) begin
            if (in_valid) begin
                pending_pairs.delete(0);
                pairs_sent++;
            end
            show = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (pending_pairs.size() > 0) begin
                show = 1'b1;
                in_data <= pending_pairs[0];
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                             : $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            in_valid <= show;
        end
    end

    // Receiver: ready runs and stall runs of independent random lengths.
    always @(posedge clk) begin : pace_results
        if (ready_run > 0) begin
            ready_run--;
        end else if (out_ready) begin
            out_ready <= 1'b0;
            ready_run = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20)
                                                    : $urandom_range(0, 3);
        end else begin
            out_ready <= 1'b1;
            ready_run = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2)
                                                    : $urandom_range(4, 40);
        end
    end

    // The result side is checked before the new prediction is queued, so a
    // transfer out never meets the prediction made in the same cycle.
    always @(posedge clk) begin : check_contacts
        bppc_pkg::t_contact want;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                if (expected_contacts.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("ERROR: unexpected contact %s", contact_str(out_data));
                end else begin
                    want = expected_contacts.pop_front();
                    checked++;
                    if (out_data.touching !== want.touching
                        || out_data.normal_axis !== want.normal_axis
                        || out_data.normal_negative !== want.normal_negative
                        || out_data.penetration !== want.penetration
                        || out_data.point_x !== want.point_x
                        || out_data.point_y !== want.point_y
                        || out_data.point_z !== want.point_z) begin
                        errors++;
                        if (errors <= 10) begin
                            $display("ERROR: contact %0d differs", checked);
                            $display("  expected %s", contact_str(want));
                            $display("  actual   %s", contact_str(out_data));
                        end
                    end
                    if (want.touching) begin
                        touch_count++;
                        axis_hits[want.normal_axis]++;
                        if (want.normal_negative)
                            neg_count++;
                        if (longint'(want.penetration) == PEN_MAX)
                            sat_count++;
                    end else begin
                        apart_count++;
                    end
                end
            end
            if (in_valid && in_ready)
                expected_contacts.insert(expected_contacts.size(),
                                         predict_contact(in_data, cur_slop));
        end
    end

    always @(posedge clk) begin : watchdog
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("ERROR: no transfer for %0d cycles, %0d contacts outstanding",
                     quiet_cycles, expected_contacts.size());
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : run_test
        bppc_pkg::t_box_pair bp;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        add_pair(uniform_pair(0, 0, 0, 0));
        add_pair(uniform_pair(0, ONE, 0, ONE));
        // A gap equal to the reset slop still touches; one more unit is apart.
        add_pair(uniform_pair(0, ONE, 2 * ONE + 7, ONE));
        add_pair(uniform_pair(0, ONE, 2 * ONE + 8, ONE));
        bp = uniform_pair(0, ONE, 0, ONE);
        bp.right_center_y = ONE;
        add_pair(bp);
        bp = uniform_pair(0, ONE, 0, ONE);
        bp.right_center_z = -ONE;
        add_pair(bp);
        bp = uniform_pair(0, ONE, 0, ONE);
        bp.right_center_x = ONE;
        bp.right_center_y = ONE;
        add_pair(bp);
        bp = uniform_pair(0, ONE, 0, ONE);
        bp.right_center_y = ONE;
        bp.right_center_z = -ONE;
        add_pair(bp);
        bp = uniform_pair(0, ONE, 0, ONE);
        bp.right_center_x = -ONE;
        bp.right_center_z = ONE;
        add_pair(bp);
        bp = uniform_pair(0, ONE, 0, ONE);
        bp.right_center_x = -ONE / 2;
        add_pair(bp);
        add_pair(uniform_pair(5, -ONE, 3, -3 * ONE));
        // The most negative half extent counts as 2^31; the depth saturates.
        add_pair(uniform_pair(0, COORD_MIN, 0, COORD_MIN));
        add_pair(uniform_pair(0, COORD_MAX, 0, COORD_MAX));
        add_pair(uniform_pair(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX));
        add_pair(uniform_pair(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN));
        add_pair(uniform_pair(COORD_MIN, 0, COORD_MIN, 0));
        add_pair(uniform_pair(COORD_MAX, 0, COORD_MAX, 0));
        add_pair(uniform_pair(-3, ONE, 0, ONE));
        add_pair(uniform_pair(COORD_MIN, 0, COORD_MAX, 0));
        bp = uniform_pair(100, ONE, 200, ONE);
        bp.right_center_z = 100 + 2 * ONE + 8;
        add_pair(bp);
        add_pair(uniform_pair(-1, -1, -1, -1));

        queue_random(110);
        wait_idle();
        write_slop('0);
        queue_random(105);
        wait_idle();
        write_slop('1);
        queue_random(105);
        wait_idle();
        write_slop(SW'($urandom_range(2, 65534)));
        queue_random(105);
        wait_idle();
        write_slop(SW'(1));
        queue_random(105);
        wait_idle();

        if (expected_contacts.size() != 0) begin
            errors += expected_contacts.size();
            $display("ERROR: %0d contacts never came out", expected_contacts.size());
        end
        $display("summary: %0d box pairs sent, %0d contacts checked, %0d slop writes",
                 pairs_sent, checked, slop_writes);
        $display("summary: touching %0d (x %0d, y %0d, z %0d, negative %0d, %s %0d), %s %0d",
                 touch_count, axis_hits[0], axis_hits[1], axis_hits[2], neg_count,
                 "saturated", sat_count, "apart", apart_count);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

FILE: sim.f
design/bppc_pkg.sv
design/bppc_axis.sv
design/bppc_select.sv
design/box_pair_penetration_contact.sv
design/bppc_checker.sv
test/tb.sv
